@@ rtl/svr_pkg.sv @@
// ----------------------------------------------------------------------------
// svr_pkg: shared types and constants of the sample voice resampler
// Item kinds, internal operations, register indexes, register file layout
// and the queued item that the front part hands to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package svr_pkg;

	// port widths
	localparam int S_TDATA_W   = 56;
	localparam int M_TDATA_W   = 40;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	// input item kinds as they arrive in tuser
	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_TICK    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_VOICE_ENABLE  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_START  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_LENGTH = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME        = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_INTERPOLATE   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_CONTINUE = 3'd6;

	// gain ceiling and the shortest playable length in phase units
	localparam logic [6:0]  VOLUME_MAX  = 7'h40;
	localparam logic [31:0] SHORT_LIMIT = 32'h0001_0000;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_TICK    = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [15:0]        load_address;
		logic signed [7:0]  load_byte;
		logic signed [31:0] mix_in;
	} item_t;

	typedef struct packed {
		logic        voice_enable;
		logic [15:0] sample_start;
		logic [15:0] sample_length;
		logic [23:0] phase_step;
		logic [6:0]  volume;
		logic        interpolate;
		logic        loop_continue;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/svr_front.sv @@
// ----------------------------------------------------------------------------
// svr_front: input side of the voice
// Takes requests from the input stream, decodes the kind into an operation,
// drops unknown kinds and pushes the rest into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module svr_front (
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [svr_pkg::S_TDATA_W-1:0]  s_tdata,  // load_address, load_byte, mix_in
	input  wire logic [1:0]                     s_tuser,  // kind
	input  wire logic                           q_full,
	output logic                                q_push,
	output svr_pkg::item_t                      q_item
);
	import svr_pkg::*;

	logic known;

	// the queue decides whether a request can be taken
	assign s_tready = !q_full;

	// kind decode and payload unpack
	always_comb begin
		known               = 1'b1;
		q_item.op           = OP_LOAD;
		q_item.load_address = s_tdata[15:0];
		q_item.load_byte    = s_tdata[23:16];
		q_item.mix_in       = s_tdata[55:24];
		unique case (s_tuser)
			KIND_LOAD:    q_item.op = OP_LOAD;
			KIND_TICK:    q_item.op = OP_TICK;
			KIND_RESTART: q_item.op = OP_RESTART;
			default:      known = 1'b0;
		endcase
	end

	// unknown kinds are taken and discarded
	assign q_push = s_tvalid && s_tready && known;

endmodule

`default_nettype wire

@@ rtl/svr_queue.sv @@
// ----------------------------------------------------------------------------
// svr_queue: short request queue
// Register-based FIFO that decouples the front part from the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module svr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire svr_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output svr_pkg::item_t      pop_item
);
	import svr_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t         entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

@@ rtl/svr_back.sv @@
// ----------------------------------------------------------------------------
// svr_back: execution side of the voice
// Holds the sample store and the playback state, runs loads, restarts and
// ticks in a small sequencer and keeps the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module svr_back #(
	parameter int STORE_BYTES    = 65536,
	parameter int FRACTION_WIDTH = 14
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire svr_pkg::cfg_t  cfg,
	input  wire logic           q_empty,
	input  wire svr_pkg::item_t q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [31:0]         out_mix,
	output logic                out_active
);
	import svr_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);
	localparam int FW = FRACTION_WIDTH;
	localparam int LW = 16 + FW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD2,
		S_CALC,
		S_MAC
	} state_t;

	state_t             state_q;
	logic [31:0]        phase_q;
	logic [15:0]        cur_start_q;
	logic [15:0]        cur_len_q;
	logic               playing_q;
	logic [AW-1:0]      addr2_q;
	logic [FW-1:0]      frac_q;
	logic [31:0]        mix_q;
	logic               active_q;
	logic signed [7:0]  v1_q;
	logic signed [7:0]  smp_q;
	logic [31:0]        out_mix_q;
	logic               out_active_q;
	logic               out_valid_q;
	logic               out_load;

	logic [7:0]         mem_q [STORE_BYTES];
	logic signed [7:0]  rdata_q;
	logic               mem_we;
	logic [AW-1:0]      mem_addr;

	logic [31:0]        phase_add;
	logic [31-FW:0]     idx_cur;
	logic [31-FW:0]     idx_sel;
	logic [31:0]        sum1;
	logic [31:0]        sum2;
	logic [31:0]        ss32;
	logic [31:0]        la32;
	logic               nb_in;
	logic [AW-1:0]      addr1;
	logic [AW-1:0]      addr2;
	logic [31:0]        lim;
	logic               wrap;
	logic [LW-1:0]      new_len_wide;
	logic               new_short;
	logic               live;
	logic signed [8:0]  diff;
	logic signed [FW+9:0] prod;
	logic signed [FW+9:0] prod_sh;
	logic signed [9:0]  interp_sum;
	logic [6:0]         vol;
	logic signed [15:0] scaled;
	logic [31:0]        mix_sum;

	// phase, store addresses and end-of-sample test for a tick
	always_comb begin
		phase_add    = phase_q + 32'(cfg.phase_step);
		idx_cur      = phase_q[31:FW];
		idx_sel      = cfg.interpolate ? idx_cur : phase_add[31:FW];
		sum1         = 32'(cur_start_q) + 32'(idx_sel);
		sum2         = sum1 + 32'd1;
		ss32         = 32'(cfg.sample_start);
		la32         = 32'(q_item.load_address);
		nb_in        = (33'(idx_cur) + 33'd1) < 33'(cur_len_q);
		addr1        = sum1[AW-1:0];
		addr2        = nb_in ? sum2[AW-1:0] : ss32[AW-1:0];
		lim          = 32'({cur_len_q, {FW{1'b0}}});
		wrap         = phase_add >= lim;
		new_len_wide = {cfg.sample_length, {FW{1'b0}}};
		new_short    = new_len_wide < LW'(SHORT_LIMIT);
		live         = cfg.voice_enable && playing_q;
	end

	// store port: load write, first read at dispatch, neighbor read after
	always_comb begin
		mem_we   = 1'b0;
		mem_addr = addr1;
		if (state_q == S_IDLE && !q_empty && q_item.op == OP_LOAD) begin
			mem_we   = 1'b1;
			mem_addr = la32[AW-1:0];
		end else if (state_q == S_RD2) begin
			mem_addr = addr2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_addr] <= q_item.load_byte;
		rdata_q <= mem_q[mem_addr];
	end

	// linear interpolation, floor of the scaled difference
	always_comb begin
		diff       = {rdata_q[7], rdata_q} - {v1_q[7], v1_q};
		prod       = diff * $signed({1'b0, frac_q});
		prod_sh    = prod >>> FW;
		interp_sum = {{2{v1_q[7]}}, v1_q} + prod_sh[9:0];
	end

	// gain and mix
	always_comb begin
		vol     = (cfg.volume > VOLUME_MAX) ? VOLUME_MAX : cfg.volume;
		scaled  = smp_q * $signed({1'b0, vol});
		mix_sum = mix_q + {{16{scaled[15]}}, scaled};
	end

	assign q_pop      = (state_q == S_IDLE) && !q_empty;
	assign out_load   = (state_q == S_MAC) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_mix    = out_mix_q;
	assign out_active = out_active_q;

	// sequencer, playback state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= '0;
			cur_start_q  <= '0;
			cur_len_q    <= '0;
			playing_q    <= 1'b0;
			addr2_q      <= '0;
			frac_q       <= '0;
			mix_q        <= '0;
			active_q     <= 1'b0;
			v1_q         <= '0;
			smp_q        <= '0;
			out_mix_q    <= '0;
			out_active_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						unique case (q_item.op)
							OP_RESTART: begin
								cur_start_q <= cfg.sample_start;
								phase_q     <= '0;
								cur_len_q   <= new_short ? 16'd0 : cfg.sample_length;
								playing_q   <= !new_short;
							end
							OP_TICK: begin
								mix_q <= q_item.mix_in;
								if (live) begin
									frac_q  <= phase_q[FW-1:0];
									addr2_q <= addr2;
									if (wrap) begin
										cur_start_q <= cfg.sample_start;
										if (new_short || !cfg.loop_continue) begin
											cur_len_q <= '0;
											phase_q   <= '0;
											playing_q <= 1'b0;
											active_q  <= 1'b0;
										end else begin
											cur_len_q <= cfg.sample_length;
											phase_q   <= phase_add - lim;
											active_q  <= 1'b1;
										end
									end else begin
										phase_q  <= phase_add;
										active_q <= 1'b1;
									end
									state_q <= cfg.interpolate ? S_RD2 : S_CALC;
								end else begin
									smp_q    <= '0;
									active_q <= playing_q;
									state_q  <= S_MAC;
								end
							end
							default: ;
						endcase
					end
				end
				S_RD2: begin
					v1_q    <= rdata_q;
					state_q <= S_CALC;
				end
				S_CALC: begin
					smp_q   <= cfg.interpolate ? interp_sum[7:0] : rdata_q;
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (out_load) begin
						out_mix_q    <= mix_sum;
						out_active_q <= active_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/sample_voice_resampler.sv @@
// ----------------------------------------------------------------------------
// sample_voice_resampler: one sample-playback voice with interpolation
// Requests on the input stream load the sample store, restart the voice or
// ask for one output sample. kind travels in s_tuser. A tick returns one
// result: the incoming mix sum plus this voice's scaled sample, and whether
// the voice still plays. Loads, restarts and unknown kinds return nothing.
// Registers are written through cfg_we / cfg_index / cfg_data; the user is to
// write them only while idle; the block does not enforce it. The sequencer
// takes one request at a time: a load or restart is done in idle; a tick
// reads the store at dispatch, then calculates and mixes (an interpolating
// one adds a second read first, a silent one only mixes); the single store
// port reads the two neighbors in turn; the next tick needs this one's phase.
// A two-entry queue keeps the input ready while the back part works, and
// the output register lets loads and restarts go on while a result waits.
// When m_tready is low the result holds, one tick waits in mix, the rest queue.
// Reset clears playback state and registers (loop_continue resets to 1);
// the sample store holds nothing defined until loaded. STORE_BYTES is a
// power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_voice_resampler #(
	parameter int STORE_BYTES    = 65536,
	parameter int FRACTION_WIDTH = 14
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [svr_pkg::S_TDATA_W-1:0]    s_tdata,  // load_address, load_byte, mix_in
	input  wire logic [1:0]                       s_tuser,  // kind
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [svr_pkg::M_TDATA_W-1:0]         m_tdata,  // mix_out, voice_active, zero pad
	input  wire logic                             cfg_we,
	input  wire logic [svr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [svr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import svr_pkg::*;

	cfg_t        cfg_q;
	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	item_t       push_item;
	item_t       pop_item;
	logic [31:0] out_mix;
	logic        out_active;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.voice_enable  <= 1'b0;
			cfg_q.sample_start  <= '0;
			cfg_q.sample_length <= '0;
			cfg_q.phase_step    <= '0;
			cfg_q.volume        <= '0;
			cfg_q.interpolate   <= 1'b0;
			cfg_q.loop_continue <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VOICE_ENABLE:  cfg_q.voice_enable  <= cfg_data[0];
				CFG_SAMPLE_START:  cfg_q.sample_start  <= cfg_data[15:0];
				CFG_SAMPLE_LENGTH: cfg_q.sample_length <= cfg_data[15:0];
				CFG_PHASE_STEP:    cfg_q.phase_step    <= cfg_data[23:0];
				CFG_VOLUME:        cfg_q.volume        <= cfg_data[6:0];
				CFG_INTERPOLATE:   cfg_q.interpolate   <= cfg_data[0];
				CFG_LOOP_CONTINUE: cfg_q.loop_continue <= cfg_data[0];
				default: ;
			endcase
		end
	end

	svr_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	svr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_item  (pop_item)
	);

	svr_back #(
		.STORE_BYTES    (STORE_BYTES),
		.FRACTION_WIDTH (FRACTION_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_item     (pop_item),
		.q_pop      (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_mix    (out_mix),
		.out_active (out_active)
	);

	// result pack
	assign m_tdata = {7'd0, out_active, out_mix};

endmodule

`default_nettype wire
